// ----- src/tcc_pkg.sv -----
// Shared constants and types for the thermal code calibration unit.
package tcc_pkg;

  // Calibration temperatures and range-check limits
  localparam int unsigned TEMP_LOW_POINT  = 25;
  localparam int unsigned TEMP_HIGH_POINT = 85;
  localparam int unsigned TEMP_SPAN       = TEMP_HIGH_POINT - TEMP_LOW_POINT;
  localparam int unsigned TEMP_MAX_CHECK  = 125;
  localparam int unsigned CODE_MIN_CHECK  = 75;
  localparam int unsigned CODE_MAX_CHECK  = 175;
  localparam int unsigned FIXED_OFFSET    = 50;

  // Saturation bounds of the result field
  localparam int RESULT_MAX = 16383;
  localparam int RESULT_MIN = -16384;
  localparam int unsigned RESULT_W = 15;

  // Widths fixed by the register map
  localparam int unsigned TRIM_W   = 8;
  localparam int unsigned DIV_W    = 8;
  localparam int unsigned ADDEND_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_HIGH   = 2'd3;

  // Calibration modes; the unused code behaves as the fixed offset mode
  localparam logic [1:0] MODE_TWO_POINT = 2'd0;
  localparam logic [1:0] MODE_ONE_POINT = 2'd1;
  localparam logic [1:0] MODE_FIXED     = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  // Commands
  localparam logic CMD_TEMP_TO_CODE = 1'b0;
  localparam logic CMD_CODE_TO_TEMP = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DIFF = 2'd2;

  // Side information that travels with the dividend down the cell row
  typedef struct packed {
    logic [1:0]                  status;
    logic                        neg;
    logic signed [ADDEND_W-1:0]  addend;
  } side_t;

endpackage

// ----- src/tcc_prep.sv -----
// Front stage: range check, operand selection, magnitude product and divisor.
module tcc_prep #(
  parameter int unsigned VALUE_WIDTH = 8,
  parameter int unsigned MAG_W       = VALUE_WIDTH + 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       command_i,
  input  logic [VALUE_WIDTH-1:0]     value_i,
  input  logic [1:0]                 cal_mode_i,
  input  logic                       range_check_i,
  input  logic [tcc_pkg::TRIM_W-1:0] trim_low_i,
  input  logic [tcc_pkg::TRIM_W-1:0] trim_high_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [MAG_W-1:0]           mag_o,
  output logic [tcc_pkg::DIV_W-1:0]  div_o,
  output tcc_pkg::side_t             side_o
);

  localparam int unsigned SW = VALUE_WIDTH + 1;

  logic                        valid_q;
  logic [MAG_W-1:0]            mag_q, mag_d;
  logic [tcc_pkg::DIV_W-1:0]   div_q, div_d;
  tcc_pkg::side_t              side_q, side_d;

  logic signed [SW-1:0]        val_s;
  logic signed [SW-1:0]        diff_temp;
  logic signed [SW-1:0]        diff_code;
  logic signed [tcc_pkg::TRIM_W:0] trim_diff;
  logic [VALUE_WIDTH-1:0]      abs_temp;
  logic [VALUE_WIDTH-1:0]      abs_code;
  logic [tcc_pkg::TRIM_W-1:0]  abs_trim;
  logic signed [tcc_pkg::ADDEND_W-1:0] lo_s;
  logic                        out_of_range;
  logic [VALUE_WIDTH-1:0]      opnd_a;
  logic [tcc_pkg::DIV_W-1:0]   opnd_b;

  // Signed differences and their magnitudes
  always_comb begin
    val_s     = signed'({1'b0, value_i});
    diff_temp = val_s - signed'(SW'(tcc_pkg::TEMP_LOW_POINT));
    diff_code = val_s - signed'({{(SW-tcc_pkg::TRIM_W){1'b0}}, trim_low_i});
    trim_diff = signed'({1'b0, trim_high_i}) - signed'({1'b0, trim_low_i});
    abs_temp  = diff_temp[SW-1] ? VALUE_WIDTH'(-diff_temp) : VALUE_WIDTH'(diff_temp);
    abs_code  = diff_code[SW-1] ? VALUE_WIDTH'(-diff_code) : VALUE_WIDTH'(diff_code);
    abs_trim  = trim_diff[tcc_pkg::TRIM_W] ? tcc_pkg::TRIM_W'(-trim_diff)
                                           : tcc_pkg::TRIM_W'(trim_diff);
    lo_s      = signed'({2'b00, trim_low_i});
  end

  // Range check of the older sensor variant
  always_comb begin
    if (command_i == tcc_pkg::CMD_TEMP_TO_CODE) begin
      out_of_range = (value_i < VALUE_WIDTH'(tcc_pkg::TEMP_LOW_POINT)) ||
                     (value_i > VALUE_WIDTH'(tcc_pkg::TEMP_MAX_CHECK));
    end else begin
      out_of_range = (value_i < VALUE_WIDTH'(tcc_pkg::CODE_MIN_CHECK)) ||
                     (value_i > VALUE_WIDTH'(tcc_pkg::CODE_MAX_CHECK));
    end
    out_of_range = out_of_range && range_check_i;
  end

  // Map every case onto |a| * b / divisor + addend
  always_comb begin
    opnd_a        = value_i;
    opnd_b        = tcc_pkg::DIV_W'(1);
    div_d         = tcc_pkg::DIV_W'(1);
    side_d.status = tcc_pkg::STATUS_OK;
    side_d.neg    = 1'b0;
    side_d.addend = '0;
    if (out_of_range) begin
      opnd_a        = '0;
      side_d.status = tcc_pkg::STATUS_RANGE;
    end else if (command_i == tcc_pkg::CMD_TEMP_TO_CODE) begin
      case (cal_mode_i)
        tcc_pkg::MODE_TWO_POINT: begin
          opnd_a        = abs_temp;
          opnd_b        = abs_trim;
          div_d         = tcc_pkg::DIV_W'(tcc_pkg::TEMP_SPAN);
          side_d.neg    = diff_temp[SW-1] ^ trim_diff[tcc_pkg::TRIM_W];
          side_d.addend = lo_s;
        end
        tcc_pkg::MODE_ONE_POINT: begin
          side_d.addend = lo_s - signed'(tcc_pkg::ADDEND_W'(tcc_pkg::TEMP_LOW_POINT));
        end
        default: begin
          side_d.addend = signed'(tcc_pkg::ADDEND_W'(tcc_pkg::FIXED_OFFSET));
        end
      endcase
    end else begin
      case (cal_mode_i)
        tcc_pkg::MODE_TWO_POINT: begin
          if (abs_trim == '0) begin
            opnd_a        = '0;
            side_d.status = tcc_pkg::STATUS_ZERO_DIFF;
          end else begin
            opnd_a        = abs_code;
            opnd_b        = tcc_pkg::DIV_W'(tcc_pkg::TEMP_SPAN);
            div_d         = abs_trim;
            side_d.neg    = diff_code[SW-1] ^ trim_diff[tcc_pkg::TRIM_W];
            side_d.addend = signed'(tcc_pkg::ADDEND_W'(tcc_pkg::TEMP_LOW_POINT));
          end
        end
        tcc_pkg::MODE_ONE_POINT: begin
          side_d.addend = signed'(tcc_pkg::ADDEND_W'(tcc_pkg::TEMP_LOW_POINT)) - lo_s;
        end
        default: begin
          side_d.addend = -signed'(tcc_pkg::ADDEND_W'(tcc_pkg::FIXED_OFFSET));
        end
      endcase
    end
    mag_d = MAG_W'(opnd_a) * MAG_W'(opnd_b);
  end

  assign ready_o = !valid_q || ready_i;

  // Hold the stage until the first cell takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mag_q  <= mag_d;
      div_q  <= div_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

// ----- src/tcc_cell.sv -----
// One cell of the divider row: resolves one quotient bit per transaction.
module tcc_cell #(
  parameter int unsigned MAG_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [tcc_pkg::DIV_W-1:0] rem_i,
  input  logic [MAG_W-1:0]          nq_i,
  input  logic [tcc_pkg::DIV_W-1:0] div_i,
  input  tcc_pkg::side_t            side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [tcc_pkg::DIV_W-1:0] rem_o,
  output logic [MAG_W-1:0]          nq_o,
  output logic [tcc_pkg::DIV_W-1:0] div_o,
  output tcc_pkg::side_t            side_o
);

  logic                        valid_q;
  logic [tcc_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [MAG_W-1:0]            nq_q, nq_d;
  logic [tcc_pkg::DIV_W-1:0]   div_q;
  tcc_pkg::side_t              side_q;

  logic [tcc_pkg::DIV_W:0]     trial;
  logic [tcc_pkg::DIV_W:0]     diff;
  logic                        fits;

  // Restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, nq_i[MAG_W-1]};
    diff  = trial - {1'b0, div_i};
    fits  = trial >= {1'b0, div_i};
    rem_d = fits ? diff[tcc_pkg::DIV_W-1:0] : trial[tcc_pkg::DIV_W-1:0];
    nq_d  = {nq_i[MAG_W-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;

  // Advance whenever the next cell is free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

// ----- src/thermal_code_calibration_unit.sv -----
// Top level of the thermal code calibration unit: config registers, cell row, output stage.
// Converts one value per transaction between degrees Celsius and a thermal sensor code and
// takes a new transaction every cycle unless a stall holds the row. It has one front stage
// holding the product, a row of VALUE_WIDTH + 8 divider cells that each resolve one
// quotient bit, and the output register that applies sign, offset and saturation. Every
// mode and direction flows through the same row.
// Stalls on the output ripple back through the row; empty slots are squeezed out.
// Configuration writes are taken every cycle and must only be issued while the unit is idle.
module thermal_code_calibration_unit #(
  parameter int unsigned VALUE_WIDTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [VALUE_WIDTH-1:0]         value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [tcc_pkg::RESULT_W-1:0] result_o,
  output logic [1:0]                     status_o
);

  localparam int unsigned MAG_W = VALUE_WIDTH + 8;
  localparam int unsigned SUM_W = MAG_W + 2;
  localparam logic signed [SUM_W-1:0] RES_MAX_S = SUM_W'(tcc_pkg::RESULT_MAX);
  localparam logic signed [SUM_W-1:0] RES_MIN_S = SUM_W'(tcc_pkg::RESULT_MIN);

  // Configuration registers
  logic [1:0]                 cal_mode_q;
  logic                       range_check_q;
  logic [tcc_pkg::TRIM_W-1:0] trim_low_q;
  logic [tcc_pkg::TRIM_W-1:0] trim_high_q;

  // Cell row links; index 0 is the front stage output
  logic                      valid_c [MAG_W+1];
  logic                      ready_c [MAG_W+1];
  logic [tcc_pkg::DIV_W-1:0] rem_c   [MAG_W+1];
  logic [MAG_W-1:0]          nq_c    [MAG_W+1];
  logic [tcc_pkg::DIV_W-1:0] div_c   [MAG_W+1];
  tcc_pkg::side_t            side_c  [MAG_W+1];

  // Output stage
  logic                                 out_valid_q;
  logic signed [tcc_pkg::RESULT_W-1:0]  result_q, result_d;
  logic [1:0]                           status_q;
  logic signed [MAG_W:0]                quot_s;
  logic signed [SUM_W-1:0]              sum;
  logic                                 out_ready;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode_q    <= tcc_pkg::MODE_ONE_POINT;
      range_check_q <= 1'b0;
      trim_low_q    <= tcc_pkg::TRIM_W'(55);
      trim_high_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tcc_pkg::REG_CAL_MODE:    cal_mode_q    <= cfg_data_i[1:0];
        tcc_pkg::REG_RANGE_CHECK: range_check_q <= cfg_data_i[0];
        tcc_pkg::REG_TRIM_LOW:    trim_low_q    <= cfg_data_i[tcc_pkg::TRIM_W-1:0];
        tcc_pkg::REG_TRIM_HIGH:   trim_high_q   <= cfg_data_i[tcc_pkg::TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  tcc_prep #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAG_W       (MAG_W)
  ) u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .cal_mode_i    (cal_mode_q),
    .range_check_i (range_check_q),
    .trim_low_i    (trim_low_q),
    .trim_high_i   (trim_high_q),
    .valid_o       (valid_c[0]),
    .ready_i       (ready_c[0]),
    .mag_o         (nq_c[0]),
    .div_o         (div_c[0]),
    .side_o        (side_c[0])
  );

  assign rem_c[0] = '0;

  // Divider row, most significant quotient bit first
  for (genvar i = 0; i < MAG_W; i++) begin : g_cell
    tcc_cell #(
      .MAG_W (MAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .rem_i   (rem_c[i]),
      .nq_i    (nq_c[i]),
      .div_i   (div_c[i]),
      .side_i  (side_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .nq_o    (nq_c[i+1]),
      .div_o   (div_c[i+1]),
      .side_o  (side_c[i+1])
    );
  end

  assign out_ready      = !out_valid_q || out_ready_i;
  assign ready_c[MAG_W] = out_ready;

  // Apply sign, add offset, saturate
  always_comb begin
    quot_s = side_c[MAG_W].neg ? -signed'({1'b0, nq_c[MAG_W]})
                               :  signed'({1'b0, nq_c[MAG_W]});
    sum    = SUM_W'(quot_s) + SUM_W'(side_c[MAG_W].addend);
    if (sum > RES_MAX_S) begin
      result_d = tcc_pkg::RESULT_W'(RES_MAX_S);
    end else if (sum < RES_MIN_S) begin
      result_d = tcc_pkg::RESULT_W'(RES_MIN_S);
    end else begin
      result_d = sum[tcc_pkg::RESULT_W-1:0];
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= valid_c[MAG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && valid_c[MAG_W]) begin
      result_q <= result_d;
      status_q <= side_c[MAG_W].status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  // A rejected or undefined conversion always reports a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != tcc_pkg::STATUS_OK) |-> result_o == '0)
    else $error("non-ok status with non-zero result");

  // The divider never sees a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c[0] |-> div_c[0] != '0)
    else $error("zero divisor entered the cell row");

  // A mode write takes effect on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == tcc_pkg::REG_CAL_MODE)
      |=> cal_mode_q == $past(cfg_data_i[1:0]))
    else $error("calibration mode write lost");

  // A stalled output stage only backs up the row where the last cell is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_c[MAG_W-1] |-> valid_c[MAG_W] && out_valid_q && !out_ready_i)
    else $error("last cell stalled without a blocked output");

endmodule
